// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the position servo with stall stop.
// ----------------------------------------------------------------------------
package pss_pkg;

  localparam int SAMPLE_BITS_DEF = 10;

  // effort and end-stop limits
  localparam int EFFORT_LIMIT  = 600;
  localparam int END_STOP_HIGH = 1020;
  localparam int PULSE_MAX     = 4095;

  // shared multiplier geometry
  localparam int MUL_A_W = 20;
  localparam int MUL_B_W = 22;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // divide by EFFORT_LIMIT through a reciprocal: floor(2^30 / 600)
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_600   = 1789569;
  localparam int NUM_W       = 19;

  // configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_GAIN_Q8          = 3'd0,
    REG_ARRIVE_TOLERANCE = 3'd1,
    REG_DEADBAND_EFFORT  = 3'd2,
    REG_NEUTRAL_PULSE_US = 3'd3,
    REG_POSITION_MAX     = 3'd4,
    REG_STALL_TIMEOUT_MS = 3'd5,
    REG_STALL_STEP       = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] gain_q8;
    logic [9:0]         arrive_tolerance;
    logic [9:0]         deadband_effort;
    logic [11:0]        neutral_pulse_us;
    logic [9:0]         position_max;
    logic [15:0]        stall_timeout_ms;
    logic [7:0]         stall_step;
  } cfg_t;

endpackage

// ===== rtl/position_servo_with_stall_stop_unit.sv =====
// ----------------------------------------------------------------------------
// position_servo_with_stall_stop_unit
// Proportional position servo with deadband, end-stop and stall stop.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transfer carries a target, a potentiometer sample
// and the millisecond time. Result channel (out_*): one transfer per input
// with drive_on, pulse_us and at_target. Both use valid/stall handshakes.
// Tuning registers sit on an APB-style port, one 32-bit word per register;
// write them only while the block is idle.
// An item that stops or detaches goes from the decide step straight to the
// done step; one that drives also passes the scale, reciprocal, back-multiply
// and fixup steps, because the gain product, the deadband scaling and the
// divide-by-600 (reciprocal multiply plus a back-multiply correction) all go
// through one shared multiplier in turn. in_stall stays high from acceptance
// until the result is loaded into the output register, so one item is in
// flight. A stalled result holds in the output register and the next item is
// accepted behind it; its result waits until the register frees.
// Reset restores the register defaults, sets the previous target to -1 and
// clears the stall anchor position and time.
// ----------------------------------------------------------------------------
module position_servo_with_stall_stop_unit #(
  parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [11:0]               in_target_pos,
  input  logic [SAMPLE_BITS-1:0]           in_measured_pos,
  input  logic [31:0]                      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_drive_on,
  output logic [11:0]                      out_pulse_us,
  output logic                             out_at_target,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import pss_pkg::*;

  cfg_t                      cfg;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  pss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pss_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  pss_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_pos   (in_target_pos),
    .in_measured_pos (in_measured_pos),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_on    (out_drive_on),
    .out_pulse_us    (out_pulse_us),
    .out_at_target   (out_at_target),
    .mul_a           (mul_a),
    .mul_b           (mul_b),
    .mul_p           (mul_p)
  );

endmodule

// ===== rtl/pss_cfg.sv =====
// ----------------------------------------------------------------------------
// pss_cfg
// APB-style register file holding the servo tuning registers.
// ----------------------------------------------------------------------------
module pss_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pss_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pss_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pss_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output pss_pkg::cfg_t                    cfg
);
  import pss_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_GAIN_Q8:          cfg_nxt.gain_q8          = $signed(pwdata[15:0]);
        REG_ARRIVE_TOLERANCE: cfg_nxt.arrive_tolerance = pwdata[9:0];
        REG_DEADBAND_EFFORT:  cfg_nxt.deadband_effort  = pwdata[9:0];
        REG_NEUTRAL_PULSE_US: cfg_nxt.neutral_pulse_us = pwdata[11:0];
        REG_POSITION_MAX:     cfg_nxt.position_max     = pwdata[9:0];
        REG_STALL_TIMEOUT_MS: cfg_nxt.stall_timeout_ms = pwdata[15:0];
        REG_STALL_STEP:       cfg_nxt.stall_step       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_Q8:          prdata = {{16{cfg_r.gain_q8[15]}}, cfg_r.gain_q8};
      REG_ARRIVE_TOLERANCE: prdata = 32'(cfg_r.arrive_tolerance);
      REG_DEADBAND_EFFORT:  prdata = 32'(cfg_r.deadband_effort);
      REG_NEUTRAL_PULSE_US: prdata = 32'(cfg_r.neutral_pulse_us);
      REG_POSITION_MAX:     prdata = 32'(cfg_r.position_max);
      REG_STALL_TIMEOUT_MS: prdata = 32'(cfg_r.stall_timeout_ms);
      REG_STALL_STEP:       prdata = 32'(cfg_r.stall_step);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_q8          <= 16'sd256;
      cfg_r.arrive_tolerance <= 10'd10;
      cfg_r.deadband_effort  <= 10'd0;
      cfg_r.neutral_pulse_us <= 12'd1500;
      cfg_r.position_max     <= 10'd1023;
      cfg_r.stall_timeout_ms <= 16'd1000;
      cfg_r.stall_step       <= 8'd8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/pss_mul.sv =====
// ----------------------------------------------------------------------------
// pss_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pss_mul (
  input  logic                                clk,
  input  logic signed [pss_pkg::MUL_A_W-1:0]  mul_a,
  input  logic signed [pss_pkg::MUL_B_W-1:0]  mul_b,
  output logic signed [pss_pkg::MUL_P_W-1:0]  mul_p
);
  import pss_pkg::*;

  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [MUL_P_W-1:0] prod_nxt;

  assign prod_nxt = mul_a * mul_b;
  assign mul_p    = prod_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/pss_core.sv =====
// ----------------------------------------------------------------------------
// pss_core
// Sequencer and datapath: stall tracking, stop decisions and effort shaping,
// driving the shared multiplier one product per step.
// ----------------------------------------------------------------------------
module pss_core #(
  parameter int SAMPLE_BITS = pss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pss_pkg::cfg_t                       cfg,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [11:0]                  in_target_pos,
  input  logic [SAMPLE_BITS-1:0]              in_measured_pos,
  input  logic [31:0]                         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_drive_on,
  output logic [11:0]                         out_pulse_us,
  output logic                                out_at_target,
  output logic signed [pss_pkg::MUL_A_W-1:0]  mul_a,
  output logic signed [pss_pkg::MUL_B_W-1:0]  mul_b,
  input  logic signed [pss_pkg::MUL_P_W-1:0]  mul_p
);
  import pss_pkg::*;

  localparam int EW = ((SAMPLE_BITS > 10) ? SAMPLE_BITS : 10) + 2;
  localparam int AW = SAMPLE_BITS + 2;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_MUL_ERR   = 8'b0000_0010,
    ST_DECIDE    = 8'b0000_0100,
    ST_MUL_SCALE = 8'b0000_1000,
    ST_MUL_RECIP = 8'b0001_0000,
    ST_MUL_BACK  = 8'b0010_0000,
    ST_FIXUP     = 8'b0100_0000,
    ST_DONE      = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic signed [11:0]      prev_target_r, prev_target_nxt;
  logic signed [AW-1:0]    anchor_pos_r, anchor_pos_nxt;
  logic [31:0]             anchor_time_r, anchor_time_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [SAMPLE_BITS-1:0]  pos_r;
  logic [31:0]             now_r;
  logic signed [EW-1:0]    err_r;
  logic                    neg_r;
  logic [9:0]              cmag_r;
  logic [9:0]              dsat_r;
  logic [NUM_W-1:0]        n_r;
  logic [9:0]              q0_r;
  logic                    res_drive_r, res_at_r;
  logic [11:0]             res_pulse_r;
  logic                    out_drive_r, out_at_r;
  logic [11:0]             out_pulse_r;

  logic                    accept, load;
  logic [9:0]              tgt_clamp;
  logic signed [EW-1:0]    err_acc;

  // decide step
  logic [EW-1:0]           aerr;
  logic [EW-1:0]           pos_w;
  logic                    prod_pos, stop_now, moved, expired, stop;
  logic signed [AW:0]      drift;
  logic [AW:0]             dabs;
  logic [AW-1:0]           pos_a, half_a;
  logic [31:0]             deadline;
  logic [MUL_P_W-1:0]      pmag;
  logic [MUL_P_W-9:0]      effmag;
  logic                    eff_zero;
  logic [9:0]              cmag, dsat;

  // fixup step
  logic [NUM_W-1:0]        rem;
  logic [9:0]              q;
  logic [10:0]             em, emc;
  logic signed [13:0]      psum;
  logic [11:0]             pulse;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign load      = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_drive_on  = out_drive_r;
  assign out_pulse_us  = out_pulse_r;
  assign out_at_target = out_at_r;

  // clamp target to 0..position_max, then take the error
  always_comb begin
    if (in_target_pos[11]) begin
      tgt_clamp = '0;
    end else if (in_target_pos[10:0] > {1'b0, cfg.position_max}) begin
      tgt_clamp = cfg.position_max;
    end else begin
      tgt_clamp = in_target_pos[9:0];
    end
  end
  assign err_acc = $signed(EW'(tgt_clamp)) - $signed(EW'(in_measured_pos));

  // stop tests
  assign aerr     = err_r[EW-1] ? EW'(-err_r) : EW'(err_r);
  assign pos_w    = EW'(pos_r);
  assign prod_pos = !mul_p[MUL_P_W-1] && (mul_p != '0);
  assign stop_now = (aerr < EW'(cfg.arrive_tolerance)) ||
                    (prod_pos && (pos_r == '0)) ||
                    (prod_pos && (pos_w > EW'(END_STOP_HIGH)));
  assign pos_a    = AW'(pos_r);
  assign half_a   = AW'(cfg.stall_step[7:1]);
  assign drift    = $signed({anchor_pos_r[AW-1], anchor_pos_r}) - $signed({1'b0, pos_a});
  assign dabs     = drift[AW] ? (AW+1)'(-drift) : (AW+1)'(drift);
  assign moved    = dabs > (AW+1)'(cfg.stall_step);
  assign deadline = anchor_time_r + 32'(cfg.stall_timeout_ms);
  assign expired  = deadline < now_r;
  assign stop     = stop_now || (!moved && expired);

  // effort = product / 256 toward zero, clamped to the effort limit
  assign pmag     = mul_p[MUL_P_W-1] ? MUL_P_W'(-mul_p) : MUL_P_W'(mul_p);
  assign effmag   = pmag[MUL_P_W-1:8];
  assign eff_zero = (effmag == '0);
  assign cmag     = (effmag > (MUL_P_W-8)'(EFFORT_LIMIT)) ? 10'(EFFORT_LIMIT) : effmag[9:0];
  assign dsat     = (cfg.deadband_effort > 10'(EFFORT_LIMIT)) ? 10'(EFFORT_LIMIT)
                                                              : cfg.deadband_effort;

  // quotient correction, deadband offset and pulse saturation
  assign rem   = n_r - mul_p[NUM_W-1:0];
  assign q     = q0_r + 10'(rem >= NUM_W'(EFFORT_LIMIT));
  assign em    = 11'(q) + 11'(dsat_r);
  assign emc   = (em > 11'(EFFORT_LIMIT)) ? 11'(EFFORT_LIMIT) : em;
  assign psum  = neg_r ? $signed(14'(cfg.neutral_pulse_us)) - $signed(14'(emc))
                       : $signed(14'(cfg.neutral_pulse_us)) + $signed(14'(emc));
  assign pulse = psum[13] ? 12'd0
               : ((psum > $signed(14'(PULSE_MAX))) ? 12'(PULSE_MAX) : psum[11:0]);

  // multiplier operand select
  always_comb begin
    unique case (state_r)
      ST_MUL_ERR: begin
        mul_a = MUL_A_W'(err_r);
        mul_b = MUL_B_W'(cfg.gain_q8);
      end
      ST_MUL_SCALE: begin
        mul_a = $signed(MUL_A_W'(cmag_r));
        mul_b = $signed(MUL_B_W'(10'(EFFORT_LIMIT) - dsat_r));
      end
      ST_MUL_RECIP: begin
        mul_a = $signed(MUL_A_W'(mul_p[NUM_W-1:0]));
        mul_b = $signed(MUL_B_W'(RECIP_600));
      end
      ST_MUL_BACK: begin
        mul_a = $signed(MUL_A_W'(mul_p[RECIP_SHIFT+9:RECIP_SHIFT]));
        mul_b = $signed(MUL_B_W'(EFFORT_LIMIT));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer and tracking state
  always_comb begin
    state_nxt       = state_r;
    prev_target_nxt = prev_target_r;
    anchor_pos_nxt  = anchor_pos_r;
    anchor_time_nxt = anchor_time_r;
    out_valid_nxt   = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MUL_ERR;
          // a new target restarts stall tracking
          if (in_target_pos != prev_target_r) begin
            prev_target_nxt = in_target_pos;
            anchor_pos_nxt  = AW'(in_measured_pos);
            anchor_time_nxt = in_now_ms;
          end
        end
      end
      ST_MUL_ERR:   state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!stop_now && moved) begin
          anchor_pos_nxt  = (!err_r[EW-1] && (err_r != '0)) ? pos_a - half_a : pos_a + half_a;
          anchor_time_nxt = now_r;
        end
        state_nxt = (stop || eff_zero) ? ST_DONE : ST_MUL_SCALE;
      end
      ST_MUL_SCALE: state_nxt = ST_MUL_RECIP;
      ST_MUL_RECIP: state_nxt = ST_MUL_BACK;
      ST_MUL_BACK:  state_nxt = ST_FIXUP;
      ST_FIXUP:     state_nxt = ST_DONE;
      ST_DONE: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      prev_target_r <= -12'sd1;
      anchor_pos_r  <= '0;
      anchor_time_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      prev_target_r <= prev_target_nxt;
      anchor_pos_r  <= anchor_pos_nxt;
      anchor_time_r <= anchor_time_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r <= in_measured_pos;
      now_r <= in_now_ms;
      err_r <= err_acc;
    end
    if (state_r == ST_DECIDE) begin
      neg_r       <= mul_p[MUL_P_W-1];
      cmag_r      <= cmag;
      dsat_r      <= dsat;
      res_drive_r <= 1'b0;
      res_pulse_r <= '0;
      res_at_r    <= stop;
    end
    if (state_r == ST_MUL_RECIP) begin
      n_r <= mul_p[NUM_W-1:0];
    end
    if (state_r == ST_MUL_BACK) begin
      q0_r <= mul_p[RECIP_SHIFT+9:RECIP_SHIFT];
    end
    if (state_r == ST_FIXUP) begin
      res_drive_r <= 1'b1;
      res_pulse_r <= pulse;
      res_at_r    <= 1'b0;
    end
    // hold the result while the receiver stalls
    if (load) begin
      out_drive_r <= res_drive_r;
      out_pulse_r <= res_pulse_r;
      out_at_r    <= res_at_r;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_MUL_ERR)
    else $error("accepted transfer did not start the sequence");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result appeared outside the done step");

  a_stop_detached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_at_r |-> !out_drive_r && out_pulse_r == '0)
    else $error("stop result still drives the servo");

  a_detach_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_drive_r |-> out_pulse_r == '0)
    else $error("detached result carries a pulse width");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the position servo with stall stop. Drives target,
// sample and time items through the valid/stall input channel, tunes the
// block through its APB-style port while no item is in flight, predicts every servo
// command and compares it field by field with what leaves the output channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pss_pkg::*;

  typedef struct packed {
    logic        drive_on;
    logic [11:0] pulse_us;
    logic        at_target;
  } servo_cmd_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [11:0]      in_target_pos;
  logic [9:0]              in_measured_pos;
  logic [31:0]             in_now_ms;
  logic                    out_valid;
  logic                    out_stall;
  logic                    out_drive_on;
  logic [11:0]             out_pulse_us;
  logic                    out_at_target;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CFG_ADDR_W-1:0]   paddr;
  logic [CFG_DATA_W-1:0]   pwdata;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;

  // register mirror
  logic signed [15:0] cfg_gain;
  logic [9:0]         cfg_arrive_tol;
  logic [9:0]         cfg_deadband;
  logic [11:0]        cfg_neutral;
  logic [9:0]         cfg_position_max;
  logic [15:0]        cfg_stall_timeout;
  logic [7:0]         cfg_stall_step;

  // stall tracking mirror
  int          last_target;
  int          anchor_pos;
  logic [31:0] anchor_ms;

  servo_cmd_t  pending_cmds[$];
  int          mismatches;
  int          gap_pct;
  int          stall_pct;
  logic        out_hold;
  logic [31:0] ms_clock;

  position_servo_with_stall_stop_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_pos   (in_target_pos),
    .in_measured_pos (in_measured_pos),
    .in_now_ms       (in_now_ms),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drive_on    (out_drive_on),
    .out_pulse_us    (out_pulse_us),
    .out_at_target   (out_at_target),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("** position_servo_with_stall_stop_unit: FAILED **");
    $finish;
  end

  function automatic void servo_reset();
    cfg_gain          = 16'sd256;
    cfg_arrive_tol    = 10'd10;
    cfg_deadband      = 10'd0;
    cfg_neutral       = 12'd1500;
    cfg_position_max  = 10'd1023;
    cfg_stall_timeout = 16'd1000;
    cfg_stall_step    = 8'd8;
    last_target       = -1;
    anchor_pos        = 0;
    anchor_ms         = '0;
  endfunction

  function automatic servo_cmd_t predict_servo(logic signed [11:0] tgt, logic [9:0] meas,
                                               logic [31:0] now);
    int          raw, pos, pmax, tol, step, half, goal, err, aerr, drift;
    longint      prod, eff, dband, c, scaled, e, p;
    logic [31:0] deadline;
    logic        halt;
    servo_cmd_t  r;
    raw  = tgt;
    pos  = meas;
    pmax = cfg_position_max;
    tol  = cfg_arrive_tol;
    step = cfg_stall_step;
    half = step / 2;
    halt = 1'b0;
    r    = '0;
    // a new raw target restarts stall tracking
    if (raw != last_target) begin
      last_target = raw;
      anchor_pos  = pos;
      anchor_ms   = now;
    end
    goal = raw < 0 ? 0 : (raw > pmax ? pmax : raw);
    err  = goal - pos;
    prod = longint'(err) * longint'(cfg_gain);
    aerr = err < 0 ? -err : err;
    drift = anchor_pos - pos;
    if (drift < 0) drift = -drift;
    deadline = anchor_ms + {16'd0, cfg_stall_timeout};
    if (aerr < tol || (prod > 0 && (pos == 0 || pos > END_STOP_HIGH))) begin
      halt = 1'b1;
    end else if (drift > step) begin
      anchor_pos = err > 0 ? pos - half : pos + half;
      anchor_ms  = now;
    end else if (deadline < now) begin
      halt = 1'b1;
    end
    if (halt) begin
      r.at_target = 1'b1;
    end else begin
      eff = prod / 256;
      if (eff != 0) begin
        dband  = cfg_deadband;
        if (dband > EFFORT_LIMIT) dband = EFFORT_LIMIT;
        c      = eff > EFFORT_LIMIT ? EFFORT_LIMIT : (eff < -EFFORT_LIMIT ? -EFFORT_LIMIT : eff);
        scaled = c * (EFFORT_LIMIT - dband) / EFFORT_LIMIT;
        // offset sign follows the unscaled effort
        e = c > 0 ? scaled + dband : scaled - dband;
        if (e > EFFORT_LIMIT) e = EFFORT_LIMIT;
        if (e < -EFFORT_LIMIT) e = -EFFORT_LIMIT;
        p = e + longint'(cfg_neutral);
        if (p < 0) p = 0;
        if (p > PULSE_MAX) p = PULSE_MAX;
        r.drive_on = 1'b1;
        r.pulse_us = p[11:0];
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(string what, servo_cmd_t want, servo_cmd_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected drive_on=%0d pulse_us=%0d at_target=%0d, got %0d %0d %0d",
               $realtime, what, want.drive_on, want.pulse_us, want.at_target,
               got.drive_on, got.pulse_us, got.at_target);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin : chk_result
    servo_cmd_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_drive_on, out_pulse_us, out_at_target};
      if (pending_cmds.size() == 0) begin
        note_mismatch("result with nothing pending", '0, got);
      end else begin
        want = pending_cmds.pop_front();
        if (got.drive_on !== want.drive_on || got.pulse_us !== want.pulse_us ||
            got.at_target !== want.at_target)
          note_mismatch("servo command mismatch", want, got);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= out_hold || ($urandom_range(99) < stall_pct);
  end

  task automatic apb_write(reg_idx_t idx, logic [31:0] value);
    // drop the offer and drain every transfer in flight first
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_Q8:          cfg_gain          = value[15:0];
      REG_ARRIVE_TOLERANCE: cfg_arrive_tol    = value[9:0];
      REG_DEADBAND_EFFORT:  cfg_deadband      = value[9:0];
      REG_NEUTRAL_PULSE_US: cfg_neutral       = value[11:0];
      REG_POSITION_MAX:     cfg_position_max  = value[9:0];
      REG_STALL_TIMEOUT_MS: cfg_stall_timeout = value[15:0];
      REG_STALL_STEP:       cfg_stall_step    = value[7:0];
      default: ;
    endcase
  endtask

  // Offer one item; valid stays high on return so back-to-back items need
  // no drop in between.
  task automatic send_item(logic signed [11:0] tgt, logic [9:0] meas, logic [31:0] now);
    int gap;
    gap = 0;
    while ($urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_target_pos   <= tgt;
    in_measured_pos <= meas;
    in_now_ms       <= now;
    do @(posedge clk); while (in_stall);
    pending_cmds.push_back(predict_servo(tgt, meas, now));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic test_defaults();
    send_item(-12'sd1, 10'd500, 32'd0);      // first target equal to reset value
    send_item(-12'sd2048, 10'd0, 32'd1);
    send_item(12'sd2047, 10'd1023, 32'd2);
    send_item(12'sd1023, 10'd0, 32'd3);      // push into low end stop
    send_item(12'sd600, 10'd300, 32'd100);
    send_item(12'sd600, 10'd302, 32'd1100);  // timeout just not exceeded
    send_item(12'sd600, 10'd302, 32'd1101);  // stall stop
    send_item(12'sd700, 10'd300, 32'hFFFF_FF00);
    send_item(12'sd700, 10'd301, 32'hFFFF_FFFF);  // wrapped deadline
    settle();
  endtask

  task automatic test_gain_extremes();
    apb_write(REG_ARRIVE_TOLERANCE, 32'd0);
    apb_write(REG_GAIN_Q8, 32'd1);
    send_item(12'sd10, 10'd5, 32'd0);        // effort truncates to zero
    send_item(12'sd10, 10'd15, 32'd1);
    apb_write(REG_GAIN_Q8, 32'h0000_8000);
    send_item(12'sd0, 10'd1021, 32'd2);      // push into high end stop
    send_item(12'sd1023, 10'd500, 32'd3);
    apb_write(REG_GAIN_Q8, 32'h0000_7FFF);
    send_item(12'sd1023, 10'd1, 32'd4);
    settle();
  endtask

  task automatic test_deadband_and_pulse();
    apb_write(REG_GAIN_Q8, 32'd256);
    apb_write(REG_DEADBAND_EFFORT, 32'd599);
    send_item(12'sd520, 10'd500, 32'd0);
    send_item(12'sd480, 10'd500, 32'd1);
    apb_write(REG_DEADBAND_EFFORT, 32'd1023);  // acts as the effort limit
    send_item(12'sd520, 10'd500, 32'd2);
    send_item(12'sd480, 10'd500, 32'd3);
    apb_write(REG_DEADBAND_EFFORT, 32'd0);
    apb_write(REG_NEUTRAL_PULSE_US, 32'd4095);
    send_item(12'sd1023, 10'd100, 32'd4);    // saturate high
    apb_write(REG_NEUTRAL_PULSE_US, 32'd0);
    send_item(12'sd0, 10'd900, 32'd5);       // saturate low
    settle();
  endtask

  task automatic test_limits();
    apb_write(REG_NEUTRAL_PULSE_US, 32'd1500);
    apb_write(REG_POSITION_MAX, 32'd0);
    send_item(12'sd500, 10'd0, 32'd0);
    send_item(12'sd500, 10'd50, 32'd1);
    apb_write(REG_POSITION_MAX, 32'd1023);
    apb_write(REG_STALL_TIMEOUT_MS, 32'd0);
    apb_write(REG_STALL_STEP, 32'd255);
    send_item(12'sd400, 10'd100, 32'd10);
    send_item(12'sd400, 10'd101, 32'd11);
    apb_write(REG_STALL_TIMEOUT_MS, 32'd65535);
    apb_write(REG_STALL_STEP, 32'd0);
    send_item(12'sd300, 10'd100, 32'd20);
    send_item(12'sd300, 10'd101, 32'd21);
    apb_write(REG_ARRIVE_TOLERANCE, 32'd1023);
    send_item(12'sd1023, 10'd0, 32'd30);
    send_item(12'sd100, 10'd0, 32'd31);
    settle();
  endtask

  task automatic shuffle_config();
    apb_write(REG_GAIN_Q8, $urandom_range(99) < 60 ? $urandom_range(64, 1024)
                          : ($urandom_range(99) < 50 ? -$urandom_range(64, 1024)
                                                     : $urandom));
    apb_write(REG_ARRIVE_TOLERANCE, $urandom_range(99) < 85 ? $urandom_range(0, 30)
                                                            : $urandom_range(0, 1023));
    apb_write(REG_DEADBAND_EFFORT, $urandom_range(99) < 70 ? $urandom_range(0, 599)
                                                           : $urandom_range(0, 1023));
    apb_write(REG_NEUTRAL_PULSE_US, $urandom_range(99) < 80 ? $urandom_range(1000, 2000)
                                                            : $urandom_range(0, 4095));
    apb_write(REG_POSITION_MAX, $urandom_range(99) < 70 ? 1023 : $urandom_range(0, 1023));
    apb_write(REG_STALL_TIMEOUT_MS, $urandom_range(99) < 80 ? $urandom_range(0, 1500)
                                                            : $urandom_range(0, 65535));
    apb_write(REG_STALL_STEP, $urandom_range(99) < 70 ? $urandom_range(0, 32)
                                                      : $urandom_range(0, 255));
  endtask

  // Mostly move runs toward a held target with advancing time; the rest is
  // unrelated noise.
  task automatic run_traffic(int n_items);
    int sent, len, tgt, pos, delta;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 20) begin
        send_item(12'($urandom_range(4095)), 10'($urandom_range(1023)), $urandom);
        sent++;
      end else begin
        tgt = $urandom_range(99) < 10 ? int'($urandom_range(4095)) - 2048
                                      : int'($urandom_range(1023));
        pos = $urandom_range(1023);
        len = $urandom_range(2, 24);
        repeat (len) begin
          send_item(12'(tgt), 10'(pos), ms_clock);
          sent++;
          ms_clock += $urandom_range(0, 120);
          if ($urandom_range(99) < 8) ms_clock += cfg_stall_timeout + $urandom_range(1, 50);
          if ($urandom_range(99) < 70) begin
            delta = $urandom_range(0, 40);
            pos   = tgt > pos ? pos + delta : pos - delta;
          end
          if ($urandom_range(99) < 10) pos += int'($urandom_range(0, 6)) - 3;
          pos = pos < 0 ? 0 : (pos > 1023 ? 1023 : pos);
        end
      end
      // jump close to the wrap of the millisecond counter now and then
      if ($urandom_range(99) < 3) ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    end
  endtask

  task automatic test_random_phase(int send_idle, int recv_stall, int n_items);
    gap_pct   = send_idle;
    stall_pct = recv_stall;
    repeat (2) begin
      shuffle_config();
      run_traffic(n_items / 2);
      settle();
    end
  endtask

  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    fork
      begin : long_hold
        int n;
        out_hold <= 1'b1;
        for (n = 0; n < 300; n++) @(posedge clk);
        out_hold <= 1'b0;
      end
    join_none
    run_traffic(40);
    settle();
  endtask

  initial begin : main_seq
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_target_pos   = '0;
    in_measured_pos = '0;
    in_now_ms       = '0;
    out_stall       = 1'b0;
    out_hold        = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    mismatches      = 0;
    gap_pct         = 0;
    stall_pct       = 0;
    ms_clock        = '0;
    servo_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_gain_extremes();
    test_deadband_and_pulse();
    test_limits();
    test_random_phase(0, 0, 400);
    test_random_phase(63, 0, 400);
    test_random_phase(0, 63, 400);
    test_random_phase(22, 22, 400);
    test_backpressure();

    mismatches += pending_cmds.size();
    if (mismatches == 0) begin
      $display("** position_servo_with_stall_stop_unit: PASSED **");
    end else begin
      $display("** position_servo_with_stall_stop_unit: FAILED **");
    end
    $finish;
  end

endmodule
